// ----- rtl/htw_pkg.sv -----
package htw_pkg;

   localparam int SlotW = 4;
   localparam int TickW = 32;
   localparam int EventW = 2;
   localparam int TIMER_SLOTS_DEF = 16;

   // bucket geometry of the wheel
   localparam int BaseBits = 8;
   localparam int UpperBits = 6;
   localparam int LevelW = 3;
   localparam int BucketIdxW = (BaseBits > UpperBits) ? BaseBits : UpperBits;
   localparam int BucketW = LevelW + BucketIdxW;

   localparam logic [63:0] BaseMask = (64'd1 << BaseBits) - 64'd1;
   localparam logic [63:0] UpperMask = (64'd1 << UpperBits) - 64'd1;

   localparam logic [EventW-1:0] EVT_FIRED = 2'd0;
   localparam logic [EventW-1:0] EVT_DONE = 2'd1;
   localparam logic [EventW-1:0] EVT_ARM = 2'd2;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_ARM = 1'b1;

   typedef struct packed {
      logic kind;
      logic [SlotW-1:0] timer_slot;
      logic [TickW-1:0] delay_ticks;
      logic repeat_req;
   } req_type;

   typedef struct packed {
      logic [EventW-1:0] event_res;
      logic [SlotW-1:0] fired_slot;
      logic [TickW-1:0] now_tick;
      logic need_schedule;
      logic last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic arm;
      logic tick;
      logic scan;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic out_free;
      logic idx_last;
   } status_type;

   // level in the top bits, index below
   function automatic logic [BucketW-1:0] bucket_of(logic [TickW-1:0] v);
      logic [63:0] x;
      logic [LevelW-1:0] lvl;
      logic [BucketIdxW-1:0] ix;
      x = {32'd0, v};
      if (x < (64'd1 << BaseBits)) begin
         lvl = '0;
         ix = BucketIdxW'(x & BaseMask);
      end else begin
         lvl = LevelW'(4);
         ix = BucketIdxW'((x >> (BaseBits + 3 * UpperBits)) & UpperMask);
         // descending so the lowest matching level wins
         for (int n = 3; n >= 1; n--) begin
            if (x < (64'd1 << (BaseBits + n * UpperBits))) begin
               lvl = LevelW'(n);
               ix = BucketIdxW'((x >> (BaseBits + (n - 1) * UpperBits)) & UpperMask);
            end
         end
      end
      return {lvl, ix};
   endfunction

endpackage

// ----- rtl/htw_ctrl.sv -----
module htw_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_kind,
   output logic req_ready,
   input  htw_pkg::status_type status,
   output htw_pkg::cmd_type cmd
);
   import htw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               if (req_kind == KIND_ARM) begin
                  cmd.arm = 1'b1;
               end else begin
                  cmd.tick = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // hold the slot while a fired request cannot be placed
            if (!(status.hit && !status.out_free)) begin
               cmd.scan = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/htw_datapath.sv -----
module htw_datapath #(
   parameter int TimerSlots = htw_pkg::TIMER_SLOTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  htw_pkg::req_type req,
   input  htw_pkg::cmd_type cmd,
   output htw_pkg::status_type status,
   output logic rsp_valid,
   input  logic rsp_ready,
   output htw_pkg::rsp_type rsp
);
   import htw_pkg::*;

   // slot field reaches at most 2**SlotW slots
   localparam int Slots = (TimerSlots < (1 << SlotW)) ? TimerSlots : (1 << SlotW);
   localparam int IdxW = $clog2(Slots);

   logic [TickW-1:0] now_ff, now_in;
   logic [BucketW-1:0] nb_ff, nb_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic fired_ff, fired_in;
   logic [Slots-1:0] armed_ff, armed_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [TickW-1:0] expiry_ff [Slots];
   logic [TickW-1:0] period_ff [Slots];
   logic repeats_ff [Slots];

   logic arm_ok;
   logic [IdxW-1:0] arm_idx;
   logic [TickW-1:0] cur_exp;
   logic [TickW-1:0] now_plus1;
   logic hit;
   logic out_free;

   assign arm_ok = (32'(req.timer_slot) < 32'(Slots));
   assign arm_idx = req.timer_slot[IdxW-1:0];
   assign cur_exp = expiry_ff[idx_ff];
   assign now_plus1 = now_ff + 32'd1;
   assign hit = armed_ff[idx_ff] && (bucket_of(cur_exp) == nb_ff) && (cur_exp <= now_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.hit = hit;
   assign status.out_free = out_free;
   assign status.idx_last = (idx_ff == IdxW'(Slots - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_comb begin
      now_in = now_ff;
      nb_in = nb_ff;
      idx_in = idx_ff;
      fired_in = fired_ff;
      armed_in = armed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.arm && arm_ok) begin
         armed_in[arm_idx] = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_in.event_res = EVT_ARM;
         rsp_in.fired_slot = req.timer_slot;
         rsp_in.now_tick = now_ff;
         rsp_in.need_schedule = 1'b0;
         rsp_in.last = 1'b1;
      end
      if (cmd.tick) begin
         now_in = now_plus1;
         nb_in = bucket_of(now_plus1);
         idx_in = '0;
         fired_in = 1'b0;
      end
      if (cmd.scan) begin
         idx_in = idx_ff + 1'b1;
         if (hit) begin
            fired_in = 1'b1;
            armed_in[idx_ff] = repeats_ff[idx_ff];
            rsp_valid_in = 1'b1;
            rsp_in.event_res = EVT_FIRED;
            rsp_in.fired_slot = SlotW'(idx_ff);
            rsp_in.now_tick = now_ff;
            rsp_in.need_schedule = 1'b0;
            rsp_in.last = 1'b0;
         end
      end
      if (cmd.done) begin
         rsp_valid_in = 1'b1;
         rsp_in.event_res = EVT_DONE;
         rsp_in.fired_slot = '0;
         rsp_in.now_tick = now_ff;
         rsp_in.need_schedule = fired_ff;
         rsp_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
         armed_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff <= now_in;
         armed_ff <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nb_ff <= nb_in;
      idx_ff <= idx_in;
      fired_ff <= fired_in;
      rsp_ff <= rsp_in;
   end

   // slot tables: written on arm, expiry rewritten on a repeating fire
   always_ff @(posedge clock) begin
      if (cmd.arm && arm_ok) begin
         expiry_ff[arm_idx] <= now_ff + req.delay_ticks;
         period_ff[arm_idx] <= req.delay_ticks;
         repeats_ff[arm_idx] <= req.repeat_req;
      end else if (cmd.scan && hit && repeats_ff[idx_ff]) begin
         expiry_ff[idx_ff] <= now_ff + period_ff[idx_ff];
      end
   end

endmodule

// ----- rtl/hierarchical_timer_wheel_core.sv -----
// Timer wheel with up to 16 slots. An arm request yields one arm-accepted
// response; a request naming a slot beyond the configured count is dropped
// with no response. A tick request runs the tick increment, a scan of each
// slot, then the done response: the scan visits one slot per cycle through a
// single bucket compare, holding a slot while its fired response cannot be
// placed. Fired responses come out in slot order, followed by the final done
// response of the tick. A new request is taken once the previous one is
// finished and the response register is free or being drained.
module hierarchical_timer_wheel_core #(
   parameter int TIMER_SLOTS = htw_pkg::TIMER_SLOTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  htw_pkg::req_type req,
   output logic rsp_valid,
   input  logic rsp_ready,
   output htw_pkg::rsp_type rsp
);
   import htw_pkg::*;

   cmd_type cmd;
   status_type status;

   htw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   htw_datapath #(
      .TimerSlots (TIMER_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule
